FILE: sv/ggcpm_pkg.sv
// Shared widths, constants and types of the greedy grid cut prefix minimum block.
package ggcpm_pkg;

	localparam int POS_W    = 6;
	localparam int DIM_W    = 7;
	localparam int COST_W   = 32;
	localparam int WT_W     = 31;
	localparam int KEY_W    = 32;
	localparam int ACC_W    = 48;
	localparam int GAIN_W   = 35;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic rd_en;
		logic commit;
		logic clear;
		logic set;
	} bm_ctrl_t;

	typedef struct packed {
		logic left;
		logic right;
		logic up;
		logic down;
	} nbr_t;

endpackage

FILE: sv/ggcpm_bitmap.sv
// Row-organised membership bitmap with three row read ports, row valid bits and write forwarding.
module ggcpm_bitmap #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ggcpm_pkg::bm_ctrl_t        ctrl,
	input  logic [ggcpm_pkg::POS_W-1:0] rd_row,
	input  logic [ggcpm_pkg::POS_W-1:0] cur_col,
	input  logic [ggcpm_pkg::POS_W-1:0] cur_row,
	output ggcpm_pkg::nbr_t            nbr
);
	import ggcpm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	typedef logic [MAX_WIDTH-1:0] word_t;

	word_t mem_up  [MAX_HEIGHT];
	word_t mem_mid [MAX_HEIGHT];
	word_t mem_dn  [MAX_HEIGHT];

	logic [MAX_HEIGHT-1:0] row_valid_q;
	logic [RW-1:0] ra_up, ra_mid, ra_dn;
	logic [RW-1:0] ca_up, ca_mid, ca_dn;
	word_t rd_up_s1, rd_mid_s1, rd_dn_s1, fwd_word_s1;
	logic hit_up_s1, hit_mid_s1, hit_dn_s1;
	word_t eff_up, eff_mid, eff_dn, wr_word;
	logic wr_en;
	logic [CW-1:0] ic_left, ic_mid, ic_right;

	assign ra_up  = RW'({1'b0, rd_row} - DIM_W'(1));
	assign ra_mid = RW'(rd_row);
	assign ra_dn  = RW'({1'b0, rd_row} + DIM_W'(1));

	assign ca_up  = RW'({1'b0, cur_row} - DIM_W'(1));
	assign ca_mid = RW'(cur_row);
	assign ca_dn  = RW'({1'b0, cur_row} + DIM_W'(1));

	assign ic_left  = CW'({1'b0, cur_col} - DIM_W'(1));
	assign ic_mid   = CW'(cur_col);
	assign ic_right = CW'({1'b0, cur_col} + DIM_W'(1));

	// A row not written since the last clear reads as empty; a row written at the edge that
	// loaded this beat's read data is taken from the forwarded word instead.
	always_comb begin
		eff_up  = '0;
		eff_mid = '0;
		eff_dn  = '0;
		if (!ctrl.clear) begin
			if (hit_up_s1)
				eff_up = fwd_word_s1;
			else if (row_valid_q[ca_up])
				eff_up = rd_up_s1;
			if (hit_mid_s1)
				eff_mid = fwd_word_s1;
			else if (row_valid_q[ca_mid])
				eff_mid = rd_mid_s1;
			if (hit_dn_s1)
				eff_dn = fwd_word_s1;
			else if (row_valid_q[ca_dn])
				eff_dn = rd_dn_s1;
		end
	end

	assign wr_word = eff_mid | (word_t'(1) << ic_mid);
	assign wr_en   = ctrl.commit & ctrl.set;

	assign nbr.left  = eff_mid[ic_left];
	assign nbr.right = eff_mid[ic_right];
	assign nbr.up    = eff_up[ic_mid];
	assign nbr.down  = eff_dn[ic_mid];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_up[ca_mid]  <= wr_word;
			mem_mid[ca_mid] <= wr_word;
			mem_dn[ca_mid]  <= wr_word;
		end
		if (ctrl.rd_en) begin
			rd_up_s1    <= mem_up[ra_up];
			rd_mid_s1   <= mem_mid[ra_mid];
			rd_dn_s1    <= mem_dn[ra_dn];
			fwd_word_s1 <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			hit_up_s1   <= 1'b0;
			hit_mid_s1  <= 1'b0;
			hit_dn_s1   <= 1'b0;
		end else begin
			if (ctrl.commit) begin
				if (ctrl.clear)
					row_valid_q <= '0;
				if (ctrl.set)
					row_valid_q[ca_mid] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				hit_up_s1  <= wr_en && (ca_mid == ra_up);
				hit_mid_s1 <= wr_en && (ca_mid == ra_mid);
				hit_dn_s1  <= wr_en && (ca_mid == ra_dn);
			end
		end
	end

endmodule

FILE: sv/greedy_grid_cut_prefix_min_core.sv
// Top level of the greedy grid cut prefix minimum block.
// One pixel beat is accepted every clock cycle while pix_stall is low; its result beat enters the
// result register when res_stall allows. The rate is set by a single stage in which the neighbour
// bits, the gain, the saturating 48-bit running sum and the minimum compare are formed between
// the input and result registers. The membership bitmap holds one row word per grid row in three
// copies, so that the rows above, at and below the pixel are read in the same cycle, and a row
// valid bit per row gives an immediate clear at the start of a pass: no clearing sweep is needed
// after reset. Grid size registers must only be written while no beat is in flight.
module greedy_grid_cut_prefix_min_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ggcpm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ggcpm_pkg::DIM_W-1:0]           cfg_data,
	input  logic                                  pix_valid,
	output logic                                  pix_stall,
	input  logic                                  first_of_pass,
	input  logic [ggcpm_pkg::POS_W-1:0]           col,
	input  logic [ggcpm_pkg::POS_W-1:0]           row,
	input  logic signed [ggcpm_pkg::COST_W-1:0]   unary_cost,
	input  logic [ggcpm_pkg::WT_W-1:0]            weight_left,
	input  logic [ggcpm_pkg::WT_W-1:0]            weight_right,
	input  logic [ggcpm_pkg::WT_W-1:0]            weight_up,
	input  logic [ggcpm_pkg::WT_W-1:0]            weight_down,
	input  logic signed [ggcpm_pkg::KEY_W-1:0]    sort_key,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [ggcpm_pkg::ACC_W-1:0]    prefix_value,
	output logic signed [ggcpm_pkg::ACC_W-1:0]    best_value,
	output logic signed [ggcpm_pkg::KEY_W-1:0]    best_key,
	output logic                                  improved
);
	import ggcpm_pkg::*;

	function automatic logic signed [GAIN_W-1:0] edge_term(input logic [WT_W-1:0] w,
			input logic member, input logic use_edge);
		logic signed [GAIN_W-1:0] x;
		x = signed'(GAIN_W'(w));
		if (!use_edge)
			return '0;
		return member ? -x : x;
	endfunction

	logic [DIM_W-1:0] grid_width_q, grid_height_q, w_eff, h_eff;
	logic pix_accept, s1_valid_q, s1_adv, res_valid_q;
	logic fop_s1;
	logic [POS_W-1:0] col_s1, row_s1;
	logic signed [COST_W-1:0] unary_s1;
	logic [WT_W-1:0] wl_s1, wr_s1, wu_s1, wd_s1;
	logic signed [KEY_W-1:0] key_s1;
	bm_ctrl_t bm_ctrl;
	nbr_t nbr;
	logic in_grid, has_left, has_right, has_up, has_down;
	logic signed [GAIN_W-1:0] gain;
	logic signed [ACC_W-1:0] base_sum, base_min, sat_sum, new_sum, new_min;
	logic signed [KEY_W-1:0] base_key, new_key;
	logic signed [ACC_W:0] sum_ext;
	logic lower;
	logic signed [ACC_W-1:0] sum_q, min_q;
	logic signed [KEY_W-1:0] key_q;
	logic improved_q;

	assign pix_accept = pix_valid & ~pix_stall;
	assign s1_adv     = s1_valid_q & (~res_valid_q | ~res_stall);
	assign pix_stall  = s1_valid_q & res_valid_q & res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_RESET;
			grid_height_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (grid_width_q == '0)
			w_eff = DIM_W'(1);
		else if (grid_width_q > MAX_WIDTH)
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = grid_width_q;
		if (grid_height_q == '0)
			h_eff = DIM_W'(1);
		else if (grid_height_q > MAX_HEIGHT)
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = grid_height_q;
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			fop_s1   <= first_of_pass;
			col_s1   <= col;
			row_s1   <= row;
			unary_s1 <= unary_cost;
			wl_s1    <= weight_left;
			wr_s1    <= weight_right;
			wu_s1    <= weight_up;
			wd_s1    <= weight_down;
			key_s1   <= sort_key;
		end
	end

	assign in_grid   = ({1'b0, col_s1} < w_eff) && ({1'b0, row_s1} < h_eff);
	assign has_left  = col_s1 != '0;
	assign has_right = ({1'b0, col_s1} + DIM_W'(1)) < w_eff;
	assign has_up    = row_s1 != '0;
	assign has_down  = ({1'b0, row_s1} + DIM_W'(1)) < h_eff;

	assign bm_ctrl.rd_en  = pix_accept;
	assign bm_ctrl.commit = s1_adv;
	assign bm_ctrl.clear  = fop_s1;
	assign bm_ctrl.set    = in_grid;

	ggcpm_bitmap #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bm_ctrl),
		.rd_row (row),
		.cur_col(col_s1),
		.cur_row(row_s1),
		.nbr    (nbr)
	);

	always_comb begin
		gain = -GAIN_W'(unary_s1)
			+ edge_term(wl_s1, nbr.left, has_left)
			+ edge_term(wr_s1, nbr.right, has_right)
			+ edge_term(wu_s1, nbr.up, has_up)
			+ edge_term(wd_s1, nbr.down, has_down);

		base_sum = fop_s1 ? '0 : sum_q;
		base_min = fop_s1 ? ACC_MAX : min_q;
		base_key = fop_s1 ? '0 : key_q;

		sum_ext = {base_sum[ACC_W-1], base_sum} + (ACC_W+1)'(gain);
		if (sum_ext[ACC_W] != sum_ext[ACC_W-1])
			sat_sum = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
		else
			sat_sum = sum_ext[ACC_W-1:0];

		lower   = in_grid && (sat_sum < base_min);
		new_sum = in_grid ? sat_sum : base_sum;
		new_min = lower ? sat_sum : base_min;
		new_key = lower ? key_s1 : base_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			sum_q       <= '0;
			min_q       <= ACC_MAX;
			key_q       <= '0;
			improved_q  <= 1'b0;
		end else begin
			if (pix_accept)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;
			if (s1_adv) begin
				res_valid_q <= 1'b1;
				sum_q       <= new_sum;
				min_q       <= new_min;
				key_q       <= new_key;
				improved_q  <= lower;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign prefix_value = sum_q;
	assign best_value   = min_q;
	assign best_key     = key_q;
	assign improved     = improved_q;

	a_improved_is_min: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && improved_q |-> min_q == sum_q)
		else $error("improved beat whose minimum differs from its running sum");

	a_stall_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> s1_valid_q && res_valid_q)
		else $error("input stalled with a free pipeline");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(sum_q) && $stable(min_q) && $stable(key_q))
		else $error("accumulator state changed without a beat advancing");

	a_outside_no_gain: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !in_grid |=> !improved_q)
		else $error("pixel outside the grid lowered the minimum");

endmodule

FILE: verif/greedy_grid_cut_prefix_min_core_tb.sv
// Self-checking testbench of the greedy grid cut prefix minimum block, with its own cut predictor.
module greedy_grid_cut_prefix_min_core_tb;
	import ggcpm_pkg::*;

	localparam int MAX_W = 64;
	localparam int MAX_H = 64;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPEAT_BEATS = 120;
	localparam longint SUM_HI = (64'sd1 <<< 47) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam logic signed [COST_W-1:0] COST_LO = {1'b1, {(COST_W-1){1'b0}}};
	localparam logic signed [COST_W-1:0] COST_HI = {1'b0, {(COST_W-1){1'b1}}};
	localparam logic [WT_W-1:0] WT_HI = '1;

	typedef struct packed {
		logic                     first;
		logic [POS_W-1:0]         col;
		logic [POS_W-1:0]         row;
		logic signed [COST_W-1:0] cost;
		logic [WT_W-1:0]          wl;
		logic [WT_W-1:0]          wr;
		logic [WT_W-1:0]          wu;
		logic [WT_W-1:0]          wd;
		logic signed [KEY_W-1:0]  key;
	} pixel_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] sum;
		logic signed [ACC_W-1:0] best;
		logic signed [KEY_W-1:0] key;
		logic                    improved;
	} prefix_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = CFG_GRID_WIDTH;
	logic [DIM_W-1:0]         cfg_data = '0;
	logic                     pix_valid = 1'b0;
	logic                     pix_stall;
	logic                     first_of_pass = 1'b0;
	logic [POS_W-1:0]         col = '0;
	logic [POS_W-1:0]         row = '0;
	logic signed [COST_W-1:0] unary_cost = '0;
	logic [WT_W-1:0]          weight_left = '0;
	logic [WT_W-1:0]          weight_right = '0;
	logic [WT_W-1:0]          weight_up = '0;
	logic [WT_W-1:0]          weight_down = '0;
	logic signed [KEY_W-1:0]  sort_key = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	logic signed [ACC_W-1:0]  prefix_value;
	logic signed [ACC_W-1:0]  best_value;
	logic signed [KEY_W-1:0]  best_key;
	logic                     improved;

	// Predictor state: membership bitmap, running sum, minimum and its key.
	logic [MAX_W-1:0] member [MAX_H];
	longint           run_sum;
	longint           run_min;
	longint           min_key;
	logic [DIM_W-1:0] grid_w_raw = DIM_RESET;
	logic [DIM_W-1:0] grid_h_raw = DIM_RESET;

	prefix_t expected_prefix_q[$];
	int      mismatches = 0;
	int      src_idle_pct = 0;
	int      rcv_stall_pct = 0;
	logic    holding = 1'b0;
	event    hold_request;

	greedy_grid_cut_prefix_min_core #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.first_of_pass(first_of_pass),
		.col(col),
		.row(row),
		.unary_cost(unary_cost),
		.weight_left(weight_left),
		.weight_right(weight_right),
		.weight_up(weight_up),
		.weight_down(weight_down),
		.sort_key(sort_key),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.prefix_value(prefix_value),
		.best_value(best_value),
		.best_key(best_key),
		.improved(improved)
	);

	always #4 clk = ~clk;

	function automatic int eff_dim(input logic [DIM_W-1:0] raw, input int lim);
		if (raw == 0)
			return 1;
		return (raw > lim) ? lim : int'(raw);
	endfunction

	function automatic void clear_cut();
		foreach (member[i])
			member[i] = '0;
		run_sum = 0;
		run_min = SUM_HI;
		min_key = 0;
	endfunction

	function automatic longint link_term(input logic [WT_W-1:0] w, input int c, input int r);
		return member[r][c] ? -longint'(w) : longint'(w);
	endfunction

	function automatic prefix_t add_pixel_to_cut(input pixel_t p);
		int      w;
		int      h;
		int      c;
		int      r;
		longint  gain;
		longint  s;
		prefix_t res;
		w = eff_dim(grid_w_raw, MAX_W);
		h = eff_dim(grid_h_raw, MAX_H);
		c = int'(p.col);
		r = int'(p.row);
		res.improved = 1'b0;
		if (p.first)
			clear_cut();
		if (c < w && r < h) begin
			gain = -longint'(p.cost);
			if (c > 0)
				gain += link_term(p.wl, c - 1, r);
			if (c + 1 < w)
				gain += link_term(p.wr, c + 1, r);
			if (r > 0)
				gain += link_term(p.wu, c, r - 1);
			if (r + 1 < h)
				gain += link_term(p.wd, c, r + 1);
			member[r][c] = 1'b1;
			s = run_sum + gain;
			if (s > SUM_HI)
				s = SUM_HI;
			if (s < SUM_LO)
				s = SUM_LO;
			run_sum = s;
			if (s < run_min) begin
				run_min = s;
				min_key = longint'(p.key);
				res.improved = 1'b1;
			end
		end
		res.sum = run_sum[ACC_W-1:0];
		res.best = run_min[ACC_W-1:0];
		res.key = min_key[KEY_W-1:0];
		return res;
	endfunction

	function automatic pixel_t px(input logic first, input int c, input int r,
			input logic signed [COST_W-1:0] cost, input logic [WT_W-1:0] wl,
			input logic [WT_W-1:0] wr, input logic [WT_W-1:0] wu,
			input logic [WT_W-1:0] wd, input logic signed [KEY_W-1:0] key);
		pixel_t p;
		p.first = first;
		p.col = POS_W'(c);
		p.row = POS_W'(r);
		p.cost = cost;
		p.wl = wl;
		p.wr = wr;
		p.wu = wu;
		p.wd = wd;
		p.key = key;
		return p;
	endfunction

	function automatic logic [WT_W-1:0] rand_weight();
		logic [WT_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = WT_HI;
			2: v = WT_W'($urandom_range(0, 1 << 18));
			default: v = WT_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic signed [COST_W-1:0] rand_q16();
		logic signed [COST_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = COST_LO;
			2: v = COST_HI;
			3: v = $urandom_range(0, 1 << 18) - (1 << 17);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		first_of_pass <= p.first;
		col <= p.col;
		row <= p.row;
		unary_cost <= p.cost;
		weight_left <= p.wl;
		weight_right <= p.wr;
		weight_up <= p.wu;
		weight_down <= p.wd;
		sort_key <= p.key;
		do
			@(posedge clk);
		while (pix_stall !== 1'b0);
		expected_prefix_q = {expected_prefix_q, add_pixel_to_cut(p)};
	endtask

	task automatic settle();
		pix_valid <= 1'b0;
		while (expected_prefix_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_w_raw = w;
		grid_h_raw = h;
		@(posedge clk);
	endtask

	// A pass mostly stays inside a small window so that neighbours are often already members.
	task automatic run_pass(input int len, inout int in_grid);
		int     w;
		int     h;
		int     span;
		int     bc;
		int     br;
		int     c;
		int     r;
		int     k;
		pixel_t p;
		w = eff_dim(grid_w_raw, MAX_W);
		h = eff_dim(grid_h_raw, MAX_H);
		span = $urandom_range(2, 8);
		bc = $urandom_range(0, w - 1);
		br = $urandom_range(0, h - 1);
		for (int i = 0; i < len; i++) begin
			k = $urandom_range(0, 99);
			if (k < 85) begin
				c = (bc + $urandom_range(0, span - 1)) % w;
				r = (br + $urandom_range(0, span - 1)) % h;
			end else if (k < 92 && (w < MAX_W || h < MAX_H)) begin
				c = $urandom_range(0, 63);
				r = $urandom_range(0, 63);
				if (w < MAX_W)
					c = $urandom_range(w, 63);
				else
					r = $urandom_range(h, 63);
			end else begin
				c = $urandom_range(0, 63);
				r = $urandom_range(0, 63);
			end
			p = px((i == 0) || ($urandom_range(0, 63) == 0), c, r, rand_q16(), rand_weight(),
				rand_weight(), rand_weight(), rand_weight(), $urandom);
			if (c < w && r < h)
				in_grid++;
			send_pixel(p);
		end
	endtask

	task automatic test_directed();
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		write_grid(7'd64, 7'd64);
		send_pixel(px(1, 0, 0, COST_LO, WT_HI, WT_HI, WT_HI, WT_HI, COST_HI));
		send_pixel(px(0, 1, 0, '0, WT_HI, '0, '0, '0, COST_LO));
		send_pixel(px(0, 0, 0, '0, '0, WT_HI, '0, '0, 1));
		send_pixel(px(0, 5, 5, '0, '0, '0, '0, '0, 2));
		send_pixel(px(0, 63, 63, COST_HI, WT_HI, WT_HI, WT_HI, WT_HI, -1));
		send_pixel(px(0, 62, 63, COST_HI, WT_HI, WT_HI, WT_HI, WT_HI, 3));
		send_pixel(px(0, 63, 62, COST_HI, '0, '0, '0, WT_HI, 4));
		send_pixel(px(1, 63, 0, '0, WT_HI, WT_HI, WT_HI, WT_HI, 5));
		send_pixel(px(0, 42, 21, -1, 31'h2AAA_AAAA, 31'h5555_5555, 1, 2, 32'sh5555_5555));
		send_pixel(px(0, 21, 42, 1, 31'h5555_5555, 31'h2AAA_AAAA, 2, 1, 32'shAAAA_AAAA));
		settle();
		write_grid(7'd5, 7'd3);
		send_pixel(px(0, 1, 1, -7, '0, '0, '0, '0, 6));
		send_pixel(px(1, 5, 0, COST_LO, WT_HI, WT_HI, WT_HI, WT_HI, 7));
		send_pixel(px(0, 0, 3, COST_LO, WT_HI, WT_HI, WT_HI, WT_HI, 8));
		send_pixel(px(0, 4, 2, -5, 10, WT_HI, 20, WT_HI, 9));
		send_pixel(px(0, 3, 2, 0, 30, 40, 50, WT_HI, 10));
		send_pixel(px(0, 4, 1, 0, 60, WT_HI, 70, 80, 11));
		send_pixel(px(0, 63, 63, COST_LO, WT_HI, WT_HI, WT_HI, WT_HI, 12));
		send_pixel(px(0, 0, 0, 3, WT_HI, 1, WT_HI, 2, 13));
		settle();
	endtask

	// Push the running sum far up and then far down by adding one pixel over and over.
	task automatic test_repeated_pixel();
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		write_grid(7'd64, 7'd64);
		send_pixel(px(1, 5, 5, COST_LO, WT_HI, WT_HI, WT_HI, WT_HI, 1));
		for (int i = 0; i < REPEAT_BEATS; i++)
			send_pixel(px(0, 5, 5, COST_LO, WT_HI, WT_HI, WT_HI, WT_HI, i));
		send_pixel(px(1, 4, 5, '0, '0, '0, '0, '0, 0));
		send_pixel(px(0, 6, 5, '0, '0, '0, '0, '0, 0));
		send_pixel(px(0, 5, 4, '0, '0, '0, '0, '0, 0));
		send_pixel(px(0, 5, 6, '0, '0, '0, '0, '0, 0));
		for (int i = 0; i < REPEAT_BEATS; i++)
			send_pixel(px(0, 5, 5, COST_HI, WT_HI, WT_HI, WT_HI, WT_HI, -i));
		settle();
	endtask

	task automatic test_random_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input int src_pct, input int rcv_pct, input int beats);
		int in_grid;
		in_grid = 0;
		write_grid(w, h);
		src_idle_pct = src_pct;
		rcv_stall_pct = rcv_pct;
		while (in_grid < beats)
			run_pass($urandom_range(1, 40), in_grid);
		settle();
	endtask

	task automatic test_back_pressure();
		int in_grid;
		in_grid = 0;
		write_grid(7'd33, 7'd40);
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		-> hold_request;
		while (in_grid < 180)
			run_pass($urandom_range(10, 40), in_grid);
		settle();
	endtask

	always @(posedge clk)
		res_stall <= holding || ($urandom_range(0, 99) < rcv_stall_pct);

	always begin
		@(hold_request);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin : check_prefix
		prefix_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (expected_prefix_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with no pixel outstanding", $realtime);
			end else begin
				want = expected_prefix_q.pop_front();
				if (prefix_value !== want.sum || best_value !== want.best ||
						best_key !== want.key || improved !== want.improved) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected sum %0d best %0d key %0d imp %0b, got %0d %0d %0d %0b",
							$realtime, want.sum, want.best, want.key, want.improved,
							prefix_value, best_value, best_key, improved);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clear_cut();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_repeated_pixel();
		test_random_phase(7'd64, 7'd64, 0, 0, 300);
		test_random_phase(7'd0, 7'd1, 87, 0, 200);
		test_random_phase(7'd127, 7'd5, 0, 87, 280);
		test_random_phase(7'd7, 7'd127, 17, 17, 280);
		test_back_pressure();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && expected_prefix_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
